>>> src/assert_macros.svh
// assertion macros included by earliest_finish_dispatcher.sv
// expects clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/efd_pkg.sv
// earliest finish dispatcher package: transaction structs, op codes, defaults
// no dependencies
`default_nettype none

package efd_pkg;

  localparam int MAX_MACHINES_DEF = 32;
  localparam int TIME_BITS_DEF    = 20;

  localparam int PT_W      = 8;
  localparam int IDX_OUT_W = 5;
  localparam int TIME_OUT_W = 20;
  localparam int CFG_W     = 6;

  localparam logic [PT_W-1:0]  PT_RESET  = 8'hFF;
  localparam logic [CFG_W-1:0] CNT_RESET = 6'd1;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [IDX_OUT_W-1:0] machine_index;
    logic [PT_W-1:0]      proc_time;
  } cmd_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  chosen_machine;
    logic [TIME_OUT_W-1:0] finish_time;
    logic [TIME_OUT_W-1:0] makespan;
  } result_t;

endpackage

`default_nettype wire

>>> src/earliest_finish_dispatcher.sv
// earliest finish dispatcher top level: machine table memory, scan fsm, result register
// depends on efd_pkg and assert_macros.svh
// a dispatch scans the clamped machine count of entries, one memory read per machine, then writes back and strobes done
// busy stays high through scan and write-back, so no new command is taken until the dispatch is through
// a load writes its table entry directly and keeps busy low; the receiver cannot stall
// reset is synchronous: all machines read as proc time 255, busy-until 0, makespan 0
`default_nettype none
`include "assert_macros.svh"

module earliest_finish_dispatcher #(
  parameter int MAX_MACHINES = efd_pkg::MAX_MACHINES_DEF,
  parameter int TIME_BITS    = efd_pkg::TIME_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire efd_pkg::cmd_t            cmd,
  input  wire logic                     cfg_we,
  input  wire logic [efd_pkg::CFG_W-1:0] cfg_wdata,
  output logic                          done,
  output efd_pkg::result_t              result
);
  import efd_pkg::*;

  localparam int IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int CNT_W = $clog2(MAX_MACHINES + 1);
  localparam int ENT_W = PT_W + TIME_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  logic [1:0]           state;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     n_act;
  logic [CNT_W-1:0]     n_clamp;
  logic [CFG_W-1:0]     machine_count;
  logic [TIME_BITS-1:0] makespan_reg;
  logic [TIME_BITS-1:0] makespan_next;

  logic [ENT_W-1:0]     mem [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] valid;
  logic [ENT_W-1:0]     rdata;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;

  logic                 mem_we;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;

  logic [TIME_BITS-1:0] best_time;
  logic [IDX_W-1:0]     best_idx;
  logic [PT_W-1:0]      best_pt;

  logic [PT_W-1:0]      rd_pt;
  logic [TIME_BITS-1:0] rd_busy;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] fin;

  logic                 accept;
  logic                 load_ok;
  logic [8:0]           ld_ext;
  logic [8:0]           mc_ext;
  logic [8:0]           best_idx_ext;
  logic [31:0]          fin_ext;
  logic [31:0]          mks_ext;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign ld_ext  = 9'(cmd.machine_index);
  assign load_ok = accept && (cmd.op == OP_LOAD) && (ld_ext < 9'(MAX_MACHINES));
  assign mc_ext  = 9'(machine_count);

  always_comb begin
    if (mc_ext == 9'd0) begin
      n_clamp = CNT_W'(1);
    end else if (mc_ext > 9'(MAX_MACHINES)) begin
      n_clamp = CNT_W'(MAX_MACHINES);
    end else begin
      n_clamp = CNT_W'(mc_ext);
    end
  end

  assign rd_en   = (state == S_SCAN) && (cnt < n_act);
  assign rd_addr = cnt[IDX_W-1:0];

  assign rd_pt   = rd_valid ? rdata[TIME_BITS +: PT_W] : PT_RESET;
  assign rd_busy = rd_valid ? rdata[TIME_BITS-1:0] : '0;
  assign sum     = (TIME_BITS+1)'(rd_busy) + (TIME_BITS+1)'(rd_pt);
  assign fin     = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

  assign makespan_next = (best_time > makespan_reg) ? best_time : makespan_reg;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = ld_ext[IDX_W-1:0];
    wr_data = {cmd.proc_time, {TIME_BITS{1'b0}}};
    if (state == S_WB) begin
      mem_we  = 1'b1;
      wr_addr = best_idx;
      wr_data = {best_pt, best_time};
    end else if (load_ok) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata    <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
      rd_idx   <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_count <= CNT_RESET;
    end else if (cfg_we) begin
      machine_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      n_act        <= CNT_W'(1);
      makespan_reg <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (cmd.op == OP_DISPATCH)) begin
            state <= S_SCAN;
            cnt   <= '0;
            n_act <= n_clamp;
          end
        end
        S_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == n_act) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          makespan_reg <= makespan_next;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // running minimum over the entries read back, lowest index wins ties
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && (cnt != '0)) begin
      if ((cnt == CNT_W'(1)) || (fin < best_time)) begin
        best_time <= fin;
        best_idx  <= rd_idx;
        best_pt   <= rd_pt;
      end
    end
  end

  assign best_idx_ext = 9'(best_idx);
  assign fin_ext      = 32'(best_time);
  assign mks_ext      = 32'(makespan_next);

  always_ff @(posedge clk) begin
    if (state == S_WB) begin
      result.chosen_machine <= best_idx_ext[IDX_OUT_W-1:0];
      result.finish_time    <= fin_ext[TIME_OUT_W-1:0];
      result.makespan       <= mks_ext[TIME_OUT_W-1:0];
    end
  end

  `ASSERT_CLK(a_done_after_wb, !done || ($past(state) == S_WB), "done without write-back")
  `ASSERT_NEXT(a_dispatch_starts_scan, accept && (cmd.op == OP_DISPATCH), (state == S_SCAN) && (cnt == '0), "dispatch did not start scan")
  `ASSERT_CLK(a_scan_in_range, (state != S_SCAN) || (cnt <= n_act), "scan counter past machine count")
  `ASSERT_NEXT(a_makespan_covers, state == S_WB, makespan_reg >= $past(best_time), "makespan below finish time")

endmodule

`default_nettype wire
